/* sv/tcw_pkg.sv */
// Shared types and constants of the text console writer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tcw_pkg;

  // Field widths of the channel items
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int RROW_W   = 5;
  localparam int RCOL_W   = 7;
  localparam int OFFS_W   = 11;
  localparam int CELL_W   = 16;

  // Linear address unit: widest row and column over the legal geometries
  localparam int AU_ROW_W  = 6;
  localparam int AU_COL_W  = 8;
  localparam int AU_ADDR_W = 14;

  // Operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Control characters and the blank cell
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BELL    = 8'h07;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [ATTR_W-1:0] BLANK_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, CH_SPACE};

  typedef struct packed {
    logic              operation;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [RROW_W-1:0] cursor_row;
    logic [RCOL_W-1:0] cursor_col;
    logic [OFFS_W-1:0] cursor_offset;
    logic              scrolled;
  } result_t;

endpackage

`default_nettype wire

/* sv/tcw_in_if.sv */
// Input channel of the text console writer: valid/ready plus one item.
// Depends on tcw_pkg for the field widths.
`default_nettype none

interface tcw_in_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [CHAR_W-1:0] char_code;
  logic [RROW_W-1:0] read_row;
  logic [RCOL_W-1:0] read_col;

  modport source (output valid, output operation, output char_code,
                  output read_row, output read_col, input ready);
  modport sink   (input valid, input operation, input char_code,
                  input read_row, input read_col, output ready);
endinterface

`default_nettype wire

/* sv/tcw_out_if.sv */
// Result channel of the text console writer: valid/ready plus one item.
// Depends on tcw_pkg for the field widths.
`default_nettype none

interface tcw_out_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;
  logic [RROW_W-1:0] cursor_row;
  logic [RCOL_W-1:0] cursor_col;
  logic [OFFS_W-1:0] cursor_offset;
  logic              scrolled;

  modport source (output valid, output cell_char, output cell_attr,
                  output cursor_row, output cursor_col, output cursor_offset,
                  output scrolled, input ready);
  modport sink   (input valid, input cell_char, input cell_attr,
                  input cursor_row, input cursor_col, input cursor_offset,
                  input scrolled, output ready);
endinterface

`default_nettype wire

/* sv/text_console_writer.sv */
// Top level of the text console writer: attribute register, output register.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_seq and tcw_frame_mem.
`default_nettype none

// A text console with a ROWS x COLUMNS frame store of character/attribute
// cells and a cursor. Items are handled one at a time; in_ch.ready is high
// only while the block waits for an item. A put that does not scroll goes
// from S_EXEC to S_SHIP; a read waits in S_RDWAIT between them for the
// frame store's registered read port. Both use the shared address unit. A put
// that scrolls walks the store: each moved cell is read (S_COPY_RD) and
// written one row up (S_COPY_WR), then each cell of the bottom row is
// cleared (S_FILL). After reset a clearing pass blanks all ROWS*COLUMNS
// cells of the store before the first item is taken; attribute writes are
// taken at any time. A finished result waits in an output register until
// out_ch.ready; the next item is accepted meanwhile.
module text_console_writer #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int TAB_WIDTH   = 8,
  parameter int HEADER_ROWS = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  tcw_in_if.sink                          in_ch,
  tcw_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);
  import tcw_pkg::*;

  localparam int DEPTH  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [ATTR_W-1:0] text_attribute;
  item_t             item;
  logic              item_ready;
  logic              res_valid;
  logic              res_take;
  result_t           res;
  logic              out_valid;
  result_t           out_data;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= BLANK_ATTR;
    end else if (cfg_we) begin
      text_attribute <= cfg_wdata;
    end
  end

  // input item
  always_comb begin
    item.operation = in_ch.operation;
    item.char_code = in_ch.char_code;
    item.read_row  = in_ch.read_row;
    item.read_col  = in_ch.read_col;
  end
  assign in_ch.ready = item_ready;

  tcw_seq #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .TAB_WIDTH   (TAB_WIDTH),
    .HEADER_ROWS (HEADER_ROWS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (in_ch.valid),
    .item_ready (item_ready),
    .attr       (text_attribute),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  tcw_frame_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_take = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data <= res;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.cell_char     = out_data.cell_char;
  assign out_ch.cell_attr     = out_data.cell_attr;
  assign out_ch.cursor_row    = out_data.cursor_row;
  assign out_ch.cursor_col    = out_data.cursor_col;
  assign out_ch.cursor_offset = out_data.cursor_offset;
  assign out_ch.scrolled      = out_data.scrolled;

endmodule

`default_nettype wire

/* sv/tcw_frame_mem.sv */
// Frame store of the console: one write port, one read port, registered read.
// Depends on tcw_pkg for the cell width.
`default_nettype none

module tcw_frame_mem #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [tcw_pkg::CELL_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]         raddr,
  output      logic [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data in the cycle after the address
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/tcw_addr_unit.sv */
// Shared linear address unit: row * COLUMNS + col.
// Depends on tcw_pkg for the operand widths.
`default_nettype none

module tcw_addr_unit #(
  parameter int COLUMNS = 80
) (
  input  wire logic [tcw_pkg::AU_ROW_W-1:0]  row,
  input  wire logic [tcw_pkg::AU_COL_W-1:0]  col,
  output      logic [tcw_pkg::AU_ADDR_W-1:0] lin
);
  import tcw_pkg::*;

  logic [AU_ADDR_W-1:0] prod;

  // constant multiply, then add the column
  assign prod = AU_ADDR_W'(row) * AU_ADDR_W'(COLUMNS);
  assign lin  = prod + AU_ADDR_W'(col);

endmodule

`default_nettype wire

/* sv/tcw_seq.sv */
// Sequencer of the console: cursor, put/read handling, scroll and clear sweeps.
// Depends on tcw_pkg and drives tcw_addr_unit and the frame store ports.
`default_nettype none

module tcw_seq #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int TAB_WIDTH   = 8,
  parameter int HEADER_ROWS = 2,
  localparam int ADDR_W     = $clog2(ROWS * COLUMNS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tcw_pkg::item_t              item,
  input  wire logic                        item_valid,
  output      logic                        item_ready,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  attr,
  output      logic                        res_valid,
  input  wire logic                        res_take,
  output      tcw_pkg::result_t            res,
  output      logic                        mem_we,
  output      logic [ADDR_W-1:0]           mem_waddr,
  output      logic [tcw_pkg::CELL_W-1:0]  mem_wdata,
  output      logic [ADDR_W-1:0]           mem_raddr,
  input  wire logic [tcw_pkg::CELL_W-1:0]  mem_rdata
);
  import tcw_pkg::*;

  localparam int CW  = $clog2(COLUMNS);
  localparam int RW  = $clog2(ROWS);
  localparam int SW  = CW + 5;
  localparam int RW1 = RW + 1;
  localparam logic [ADDR_W-1:0] HDR_BASE = ADDR_W'(HEADER_ROWS * COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_END = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] CELL_END = ADDR_W'(ROWS * COLUMNS - 1);
  localparam bit HAS_COPY = (HEADER_ROWS + 1 < ROWS);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_EXEC    = 7'b0000010,
    S_RDWAIT  = 7'b0000100,
    S_COPY_RD = 7'b0001000,
    S_COPY_WR = 7'b0010000,
    S_FILL    = 7'b0100000,
    S_SHIP    = 7'b1000000
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] ptr;
  logic              clearing;
  logic [RW-1:0]     cur_row;
  logic [CW-1:0]     cur_col;

  logic              op;
  logic [CHAR_W-1:0] ch;
  logic [RROW_W-1:0] rrow;
  logic [RCOL_W-1:0] rcol;
  logic              rd_ok;
  logic [CHAR_W-1:0] res_char;
  logic [ATTR_W-1:0] res_attr;
  logic              scrolled;

  logic                 is_nl, is_tab, is_bell, is_print;
  logic [SW-1:0]        col_step, col_sum;
  logic                 wrap;
  logic [RW1-1:0]       row_sum;
  logic                 do_scroll;
  logic [RW-1:0]        new_row;
  logic [CW-1:0]        new_col;
  logic                 rd_in_range;
  logic [AU_ROW_W-1:0]  au_row;
  logic [AU_COL_W-1:0]  au_col;
  logic [AU_ADDR_W-1:0] au_lin;
  logic [15:0]          row_wide, col_wide;

  // character class of the latched put
  assign is_nl    = (ch == CH_NEWLINE);
  assign is_tab   = (ch == CH_TAB);
  assign is_bell  = (ch == CH_BELL);
  assign is_print = !is_nl && !is_tab && !is_bell;

  // cursor advance, wrap and scroll decision
  assign col_step  = is_tab ? SW'(TAB_WIDTH) : (is_print ? SW'(1) : '0);
  assign col_sum   = SW'(cur_col) + col_step;
  assign wrap      = is_nl || (col_sum >= SW'(COLUMNS));
  assign row_sum   = RW1'(cur_row) + RW1'(wrap);
  assign do_scroll = (row_sum >= RW1'(ROWS));
  assign new_row   = do_scroll ? RW'(ROWS - 1) : row_sum[RW-1:0];
  assign new_col   = wrap ? '0 : col_sum[CW-1:0];

  assign rd_in_range = (7'(rrow) < 7'(ROWS)) && (9'(rcol) < 9'(COLUMNS));

  // one address unit, shared by read lookups, puts and the cursor offset
  always_comb begin
    if (state == S_EXEC && op == OP_READ) begin
      au_row = AU_ROW_W'(rrow);
      au_col = AU_COL_W'(rcol);
    end else begin
      au_row = AU_ROW_W'(cur_row);
      au_col = AU_COL_W'(cur_col);
    end
  end

  tcw_addr_unit #(.COLUMNS(COLUMNS)) u_addr (
    .row (au_row),
    .col (au_col),
    .lin (au_lin)
  );

  // frame store requests
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = BLANK_CELL;
    mem_raddr = au_lin[ADDR_W-1:0];
    unique case (state)
      S_EXEC: begin
        if (op == OP_PUT && is_print) begin
          mem_we    = 1'b1;
          mem_waddr = au_lin[ADDR_W-1:0];
          mem_wdata = {attr, ch};
        end
      end
      S_COPY_RD: mem_raddr = ptr + ADDR_W'(COLUMNS);
      S_COPY_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      S_FILL:    mem_we = 1'b1;
      default: ;
    endcase
  end

  // sequencer and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_FILL;
      ptr      <= '0;
      clearing <= 1'b1;
      cur_row  <= '0;
      cur_col  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (op == OP_READ) begin
            state <= S_RDWAIT;
          end else begin
            cur_row <= new_row;
            cur_col <= new_col;
            if (do_scroll) begin
              ptr   <= HDR_BASE;
              state <= HAS_COPY ? S_COPY_RD : S_FILL;
            end else begin
              state <= S_SHIP;
            end
          end
        end
        S_RDWAIT:  state <= S_SHIP;
        S_COPY_RD: state <= S_COPY_WR;
        S_COPY_WR: begin
          ptr   <= ptr + 1'b1;
          state <= (ptr == COPY_END) ? S_FILL : S_COPY_RD;
        end
        S_FILL: begin
          if (ptr == CELL_END) begin
            clearing <= 1'b0;
            state    <= clearing ? S_IDLE : S_SHIP;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_SHIP: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      op   <= item.operation;
      ch   <= item.char_code;
      rrow <= item.read_row;
      rcol <= item.read_col;
    end
    if (state == S_EXEC) begin
      rd_ok    <= rd_in_range;
      scrolled <= (op == OP_PUT) && do_scroll;
      res_char <= '0;
      res_attr <= '0;
    end
    if (state == S_RDWAIT && rd_ok) begin
      res_char <= mem_rdata[CHAR_W-1:0];
      res_attr <= mem_rdata[CELL_W-1:CHAR_W];
    end
  end

  // result, fields cut to their widths
  assign row_wide = 16'(cur_row);
  assign col_wide = 16'(cur_col);

  always_comb begin
    res.cell_char     = res_char;
    res.cell_attr     = res_attr;
    res.cursor_row    = row_wide[RROW_W-1:0];
    res.cursor_col    = col_wide[RCOL_W-1:0];
    res.cursor_offset = au_lin[OFFS_W-1:0];
    res.scrolled      = scrolled;
  end

  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_SHIP);

endmodule

`default_nettype wire

/* sim/console_scoreboard.sv */
// Checker for the text console writer: watches both channels and the attribute port,
// keeps its own copy of the frame store and cursor, and compares each result item.
// Depends on tcw_pkg, tcw_in_if and tcw_out_if.
module console_scoreboard #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int TAB_WIDTH   = 8,
  parameter int HEADER_ROWS = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  tcw_in_if                          in_ch,
  tcw_out_if                         out_ch,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
  output int unsigned                mismatches,
  output int unsigned                pending,
  output int unsigned                results_seen,
  output int unsigned                reads_seen,
  output int unsigned                scrolls_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;

  // Model state: frame store, cursor, current attribute
  logic [CELL_W-1:0] frame_cells [0:CELLS-1];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [ATTR_W-1:0] text_attr;
  result_t           awaited_results [$];

  // Apply one item to the model console and return the result it produces
  function automatic result_t console_step(input item_t it);
    result_t r;
    int      rr;
    int      cc;
    r = '0;
    if (it.operation == OP_READ) begin
      if (it.read_row < ROWS && it.read_col < COLUMNS) begin
        {r.cell_attr, r.cell_char} = frame_cells[it.read_row * COLUMNS + it.read_col];
      end
    end else begin
      case (it.char_code)
        CH_NEWLINE: begin
          cur_row++;
          cur_col = 0;
        end
        CH_TAB: cur_col += TAB_WIDTH;
        CH_BELL: ;
        default: begin
          frame_cells[cur_row * COLUMNS + cur_col] = {text_attr, it.char_code};
          cur_col++;
        end
      endcase
      // wrap at the right edge, overshoot dropped
      if (cur_col >= COLUMNS) begin
        cur_row++;
        cur_col = 0;
      end
      // scroll everything below the header rows up by one
      if (cur_row >= ROWS) begin
        for (rr = HEADER_ROWS; rr + 1 < ROWS; rr++)
          for (cc = 0; cc < COLUMNS; cc++)
            frame_cells[rr * COLUMNS + cc] = frame_cells[(rr + 1) * COLUMNS + cc];
        for (cc = 0; cc < COLUMNS; cc++)
          frame_cells[(ROWS - 1) * COLUMNS + cc] = BLANK_CELL;
        cur_row    = ROWS - 1;
        r.scrolled = 1'b1;
      end
    end
    r.cursor_row    = RROW_W'(cur_row);
    r.cursor_col    = RCOL_W'(cur_col);
    r.cursor_offset = OFFS_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  // Sample both channels on the rising edge
  always @(posedge clk) begin
    item_t   it;
    result_t got;
    result_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) frame_cells[i] = BLANK_CELL;
      cur_row   = 0;
      cur_col   = 0;
      text_attr = BLANK_ATTR;
      awaited_results.delete();
      mismatches   = 0;
      results_seen = 0;
      reads_seen   = 0;
      scrolls_seen = 0;
    end else begin
      if (cfg_we) text_attr = cfg_wdata;

      // result side: compare against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        got.cell_char     = out_ch.cell_char;
        got.cell_attr     = out_ch.cell_attr;
        got.cursor_row    = out_ch.cursor_row;
        got.cursor_col    = out_ch.cursor_col;
        got.cursor_offset = out_ch.cursor_offset;
        got.scrolled      = out_ch.scrolled;
        results_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result item: char %02h attr %02h row %0d col %0d",
                     $realtime, got.cell_char, got.cell_attr, got.cursor_row, got.cursor_col);
        end else begin
          want = awaited_results.pop_front();
          if (got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
              got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
              got.cursor_offset !== want.cursor_offset || got.scrolled !== want.scrolled)
          begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result %0d differs:", $realtime, results_seen);
              $display("  expected char %02h attr %02h row %0d col %0d offset %0d scrolled %0d",
                       want.cell_char, want.cell_attr, want.cursor_row, want.cursor_col,
                       want.cursor_offset, want.scrolled);
              $display("  actual   char %02h attr %02h row %0d col %0d offset %0d scrolled %0d",
                       got.cell_char, got.cell_attr, got.cursor_row, got.cursor_col,
                       got.cursor_offset, got.scrolled);
            end
          end
        end
      end

      // input side: predict the result of each accepted item
      if (in_ch.valid && in_ch.ready) begin
        it.operation = in_ch.operation;
        it.char_code = in_ch.char_code;
        it.read_row  = in_ch.read_row;
        it.read_col  = in_ch.read_col;
        want = console_step(it);
        if (it.operation == OP_READ) reads_seen++;
        if (want.scrolled) scrolls_seen++;
        awaited_results.push_back(want);
      end
    end
    pending = awaited_results.size();
  end

endmodule

/* sim/testbench.sv */
// Top of the text console writer testbench: clock, reset, stimulus, verdict.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if, text_console_writer and console_scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int TAB_WIDTH   = 8;
  localparam int HEADER_ROWS = 2;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int HOLD_CYCLES = 300;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned holds_asked;
  int unsigned holds_granted;
  int unsigned hold_left;
  int unsigned items_sent;
  int unsigned attr_writes;
  int unsigned cycles;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned reads_seen;
  int unsigned scrolls_seen;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_writer #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_WIDTH(TAB_WIDTH), .HEADER_ROWS(HEADER_ROWS)
  ) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  console_scoreboard #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_WIDTH(TAB_WIDTH), .HEADER_ROWS(HEADER_ROWS)
  ) checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen),
    .reads_seen(reads_seen), .scrolls_seen(scrolls_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready  = 1'b0;
    holds_granted = 0;
    hold_left     = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (holds_granted < holds_asked) begin
        holds_granted++;
        hold_left    = HOLD_CYCLES - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic item_t put_op(input logic [CHAR_W-1:0] ch);
    item_t it;
    it.operation = OP_PUT;
    it.char_code = ch;
    it.read_row  = RROW_W'($urandom);
    it.read_col  = RCOL_W'($urandom);
    return it;
  endfunction

  function automatic item_t read_op(input int unsigned row, input int unsigned col);
    item_t it;
    it.operation = OP_READ;
    it.char_code = CHAR_W'($urandom);
    it.read_row  = RROW_W'(row);
    it.read_col  = RCOL_W'(col);
    return it;
  endfunction

  // Offer one item after a random gap; returns at the falling edge after acceptance
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = it.operation;
    in_ch.char_code = it.char_code;
    in_ch.read_row  = it.read_row;
    in_ch.read_col  = it.read_col;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Attribute writes happen only with the block drained
  task automatic set_attribute(input logic [ATTR_W-1:0] value);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = ATTR_W'($urandom);
    attr_writes++;
  endtask

  // One text line: mostly short, sometimes long enough to wrap, usually newline-terminated
  task automatic send_line();
    int unsigned len;
    int unsigned roll;
    len = ($urandom_range(99) < 15) ? $urandom_range(60, 100) : $urandom_range(0, 12);
    for (int unsigned k = 0; k < len; k++) begin
      roll = $urandom_range(99);
      if (roll < 70)      send_item(put_op(CHAR_W'($urandom_range(8'h20, 8'h7E))));
      else if (roll < 76) send_item(put_op(CH_TAB));
      else if (roll < 79) send_item(put_op(CH_BELL));
      else if (roll < 84) send_item(put_op(CHAR_W'($urandom)));
      else if (roll < 90) send_item(read_op($urandom_range(ROWS - 3, ROWS - 1),
                                            $urandom_range(COLUMNS - 1)));
      else if (roll < 95) send_item(read_op($urandom_range(ROWS - 1),
                                            $urandom_range(COLUMNS - 1)));
      else                send_item(read_op($urandom_range(31), $urandom_range(127)));
    end
    if ($urandom_range(9) != 0) send_item(put_op(CH_NEWLINE));
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned count, input logic [ATTR_W-1:0] attr);
    int unsigned stop_at;
    set_attribute(attr);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_line();
  endtask

  // Stimulus
  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_PUT;
    in_ch.char_code = '0;
    in_ch.read_row  = '0;
    in_ch.read_col  = '0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    holds_asked     = 0;
    items_sent      = 0;
    attr_writes     = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed: blank store, corners, out-of-range reads, edge characters, tab wrap
    send_item(read_op(0, 0));
    send_item(read_op(ROWS - 1, COLUMNS - 1));
    send_item(read_op(ROWS, 0));
    send_item(read_op(0, COLUMNS));
    send_item(read_op(31, 127));
    send_item(put_op(8'h00));
    send_item(put_op(8'hFF));
    send_item(put_op(CH_BELL));
    send_item(put_op(CH_NEWLINE));
    // ten tabs from column 0: the last one runs past the right edge
    repeat (10) send_item(put_op(CH_TAB));
    send_item(read_op(0, 0));
    send_item(read_op(0, 1));
    send_item(put_op(CH_NEWLINE));

    // Random: receiver-heavy idling, then sender-heavy, then none
    run_phase(36, 74, 340, 8'hFF);
    run_phase(74, 36, 340, 8'h00);
    holds_asked = 1;
    run_phase(0, 0, 170, ATTR_W'($urandom));
    run_phase(0, 0, 170, ATTR_W'($urandom));

    // Drain
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Covered %0d items: %0d reads, %0d scrolling puts, %0d attribute settings.",
             items_sent, reads_seen, scrolls_seen, attr_writes);
    $display("Both idling orders, a %0d-cycle receiver hold-off; %0d results in %0d cycles.",
             HOLD_CYCLES, results_seen, cycles);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d result items failed", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
